[rtl/jdp_pkg.sv]
// shared types, register codes and constants for the drive packet block
package jdp_pkg;

  localparam int unsigned LIMIT_W  = 7;
  localparam int unsigned DB_W     = 7;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ADC_W    = 12;
  localparam int unsigned FLAGS_W  = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned PROD_W   = BYTE_W + LIMIT_W;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 2**PROD_W
  localparam int unsigned RECIP_W     = 13;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
  localparam int unsigned QUOT_W = PROD_W + RECIP_W;

  localparam logic [LIMIT_W-1:0] NORMAL_LIMIT_RST = 7'd70;
  localparam logic [LIMIT_W-1:0] TURBO_LIMIT_RST  = 7'd100;
  localparam logic [DB_W-1:0]    DEADBAND_RST     = 7'd30;
  localparam logic [BYTE_W-1:0]  STICK_CENTER_RST = 8'd127;
  localparam logic [BYTE_W-1:0]  ANALOG_ID_RST    = 8'd140;

  localparam logic [BYTE_W-1:0]  BYTE_MAX = 8'hFF;

  // button bit positions in the action byte
  localparam int unsigned BTN_L1     = 2;
  localparam int unsigned BTN_R1     = 3;
  localparam int unsigned BTN_TRI    = 4;
  localparam int unsigned BTN_CIRC   = 5;
  localparam int unsigned BTN_CROSS  = 6;
  localparam int unsigned BTN_SQUARE = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_LIMIT = 3'd0,
    CFG_TURBO_LIMIT  = 3'd1,
    CFG_DEADBAND     = 3'd2,
    CFG_STICK_CENTER = 3'd3,
    CFG_ANALOG_ID    = 3'd4
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_STEP   = 2'd0,
    MODE_EXP    = 2'd1,
    MODE_LINEAR = 2'd2
  } drive_mode_t;

  typedef struct packed {
    logic fwd;
    logic rev;
  } dir_pair_t;

  typedef struct packed {
    dir_pair_t           pair;
    logic [BYTE_W-1:0]   speed;
  } lane_res_t;

  typedef struct packed {
    logic                match;
    logic [LIMIT_W-1:0]  limit;
    logic [MODE_W-1:0]   mode;
    logic [BYTE_W-1:0]   sensor;
  } side_t;

endpackage

[rtl/jdp_if.sv]
// valid/ready channel interfaces for poll frames and drive packets
interface jdp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pad_status;
  logic [7:0]  action_buttons;
  logic [7:0]  left_stick_y;
  logic [7:0]  right_stick_y;
  logic [11:0] adc_sample;

  modport source (output valid, pad_status, action_buttons, left_stick_y,
                  right_stick_y, adc_sample, input ready);
  modport sink   (input valid, pad_status, action_buttons, left_stick_y,
                  right_stick_y, adc_sample, output ready);
endinterface

interface jdp_out_if;
  logic       valid;
  logic       ready;
  logic       resync_needed;
  logic [6:0] limit_byte;
  logic [7:0] speed_a;
  logic [7:0] speed_b;
  logic [5:0] direction_flags;
  logic [7:0] sensor_byte;

  modport source (output valid, resync_needed, limit_byte, speed_a, speed_b,
                  direction_flags, sensor_byte, input ready);
  modport sink   (input valid, resync_needed, limit_byte, speed_a, speed_b,
                  direction_flags, sensor_byte, output ready);
endinterface

[rtl/jdp_lane.sv]
// one stick lane: deadband classification, magnitude, limit scaling
module jdp_lane
  import jdp_pkg::*;
(
  input  logic               clk,
  input  logic               en1,
  input  logic               en2,
  input  logic [BYTE_W-1:0]  stick,
  input  logic [BYTE_W-1:0]  center,
  input  logic [DB_W-1:0]    deadband,
  input  logic               inverted,
  input  logic [LIMIT_W-1:0] limit_s1,
  output lane_res_t          res
);

  logic signed [BYTE_W:0] off;
  logic signed [BYTE_W:0] db_pos;
  logic [BYTE_W-1:0]      abs_off;
  logic [BYTE_W-1:0]      mag;
  logic                   pos, neg, fwd;
  dir_pair_t              pair;

  dir_pair_t              pair_s1_r, pair_s2_r;
  logic [BYTE_W-1:0]      mag_s1_r;
  logic [PROD_W-1:0]      prod_s2_r;
  logic [QUOT_W-1:0]      quot;
  logic [QUOT_W-RECIP_SHIFT-1:0] speed_wide;

  always_comb begin
    off     = $signed({1'b0, stick}) - $signed({1'b0, center});
    db_pos  = $signed({2'b00, deadband});
    abs_off = off[BYTE_W] ? BYTE_W'(-off) : off[BYTE_W-1:0];
    // doubled magnitude saturates once the top bit would shift out
    mag     = abs_off[BYTE_W-1] ? BYTE_MAX : {abs_off[BYTE_W-2:0], 1'b0};
    pos     = off > db_pos;
    neg     = off < -db_pos;
    fwd     = inverted ? pos : neg;
    pair.fwd = fwd;
    pair.rev = ~fwd;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pair_s1_r <= pair;
      mag_s1_r  <= mag;
    end
    if (en2) begin
      pair_s2_r <= pair_s1_r;
      prod_s2_r <= PROD_W'(mag_s1_r * limit_s1);
    end
  end

  always_comb begin
    quot       = QUOT_W'(prod_s2_r) * QUOT_W'(RECIP_100);
    speed_wide = quot[QUOT_W-1:RECIP_SHIFT];
    res.pair   = pair_s2_r;
    res.speed  = (speed_wide > (QUOT_W-RECIP_SHIFT)'(BYTE_MAX)) ? BYTE_MAX
                                                                : speed_wide[BYTE_W-1:0];
  end

endmodule

[rtl/jdp_merge.sv]
// output register: joins both lanes and the frame side data into one packet
module jdp_merge
  import jdp_pkg::*;
(
  input  logic                clk,
  input  logic                en,
  input  side_t               side,
  input  lane_res_t           lane_a,
  input  lane_res_t           lane_b,
  output logic                resync_needed,
  output logic [LIMIT_W-1:0]  limit_byte,
  output logic [BYTE_W-1:0]   speed_a,
  output logic [BYTE_W-1:0]   speed_b,
  output logic [FLAGS_W-1:0]  direction_flags,
  output logic [BYTE_W-1:0]   sensor_byte
);

  logic                resync_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [BYTE_W-1:0]   speed_a_r, speed_b_r, sensor_r;
  logic [FLAGS_W-1:0]  flags_r;
  logic [FLAGS_W-1:0]  flags_nxt;

  assign flags_nxt = {lane_b.pair.rev, lane_b.pair.fwd, lane_a.pair.rev,
                      side.mode[1], side.mode[0], lane_a.pair.fwd};

  always_ff @(posedge clk) begin
    if (en) begin
      resync_r  <= ~side.match;
      limit_r   <= side.match ? side.limit   : '0;
      speed_a_r <= side.match ? lane_a.speed : '0;
      speed_b_r <= side.match ? lane_b.speed : '0;
      flags_r   <= side.match ? flags_nxt    : '0;
      sensor_r  <= side.match ? side.sensor  : '0;
    end
  end

  assign resync_needed   = resync_r;
  assign limit_byte      = limit_r;
  assign speed_a         = speed_a_r;
  assign speed_b         = speed_b_r;
  assign direction_flags = flags_r;
  assign sensor_byte     = sensor_r;

endmodule

[rtl/joystick_to_drive_packet_unit.sv]
// top level: gamepad poll frame in, five-byte drive packet out
// an accepted poll beat passes stage one, stage two and the output register in turn
// throughput: one frame per cycle unless out_if.ready stalls; each of the three stages
//   advances if the next has room; magnitude times limit and /100 are in separate stages
// reset (rst_n low, synchronous): pipeline emptied, flip cleared, mode linear,
//   configuration registers back to their defaults
module joystick_to_drive_packet_unit
  import jdp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  jdp_in_if.sink               in_if,
  jdp_out_if.source            out_if,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [BYTE_W-1:0]    cfg_data
);

  // configuration registers
  logic [LIMIT_W-1:0] normal_limit_r, turbo_limit_r;
  logic [DB_W-1:0]    deadband_r;
  logic [BYTE_W-1:0]  stick_center_r, analog_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_limit_r <= NORMAL_LIMIT_RST;
      turbo_limit_r  <= TURBO_LIMIT_RST;
      deadband_r     <= DEADBAND_RST;
      stick_center_r <= STICK_CENTER_RST;
      analog_id_r    <= ANALOG_ID_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_NORMAL_LIMIT: normal_limit_r <= cfg_data[LIMIT_W-1:0];
        CFG_TURBO_LIMIT:  turbo_limit_r  <= cfg_data[LIMIT_W-1:0];
        CFG_DEADBAND:     deadband_r     <= cfg_data[DB_W-1:0];
        CFG_STICK_CENTER: stick_center_r <= cfg_data;
        CFG_ANALOG_ID:    analog_id_r    <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // pipeline occupancy; each stage moves when its successor has room
  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3, accept;

  assign en3    = ~v3_r | out_if.ready;
  assign en2    = ~v2_r | en3;
  assign en1    = ~v1_r | en2;
  assign accept = in_if.valid & en1;

  assign in_if.ready  = en1;
  assign out_if.valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_if.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // button handling on the incoming beat: square, then triangle, then circle
  logic               match;
  logic [7:0]         btn;
  logic [LIMIT_W-1:0] limit;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic               flip_r, flip_nxt;

  assign btn   = in_if.action_buttons;
  assign match = (in_if.pad_status == analog_id_r);
  assign limit = (btn[BTN_L1] | btn[BTN_R1]) ? turbo_limit_r : normal_limit_r;

  always_comb begin
    mode_nxt = mode_r;
    if (btn[BTN_SQUARE]) mode_nxt = MODE_STEP;
    if (btn[BTN_TRI])    mode_nxt = MODE_LINEAR;
    if (btn[BTN_CIRC])   mode_nxt = MODE_EXP;
    flip_nxt = flip_r ^ btn[BTN_CROSS];
  end

  // drive state only moves on a beat whose status byte matched
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_LINEAR;
      flip_r <= 1'b0;
    end else if (accept && match) begin
      mode_r <= mode_nxt;
      flip_r <= flip_nxt;
    end
  end

  // frame side data travels alongside the lanes
  side_t side_in, side_s1_r, side_s2_r;

  always_comb begin
    side_in.match  = match;
    side_in.limit  = limit;
    side_in.mode   = mode_nxt;
    side_in.sensor = in_if.adc_sample[ADC_W-1:ADC_W-BYTE_W];
  end

  always_ff @(posedge clk) begin
    if (en1) side_s1_r <= side_in;
    if (en2) side_s2_r <= side_s1_r;
  end

  // flip swaps the sticks between the two lanes and inverts the sense
  logic [BYTE_W-1:0] stick_a, stick_b;
  assign stick_a = flip_nxt ? in_if.right_stick_y : in_if.left_stick_y;
  assign stick_b = flip_nxt ? in_if.left_stick_y  : in_if.right_stick_y;

  lane_res_t res_a, res_b;

  jdp_lane u_lane_a (
    .clk      (clk),
    .en1      (en1),
    .en2      (en2),
    .stick    (stick_a),
    .center   (stick_center_r),
    .deadband (deadband_r),
    .inverted (flip_nxt),
    .limit_s1 (side_s1_r.limit),
    .res      (res_a)
  );

  jdp_lane u_lane_b (
    .clk      (clk),
    .en1      (en1),
    .en2      (en2),
    .stick    (stick_b),
    .center   (stick_center_r),
    .deadband (deadband_r),
    .inverted (flip_nxt),
    .limit_s1 (side_s1_r.limit),
    .res      (res_b)
  );

  // output stage, a mismatched status gives an all-zero packet with resync set
  jdp_merge u_merge (
    .clk             (clk),
    .en              (en3),
    .side            (side_s2_r),
    .lane_a          (res_a),
    .lane_b          (res_b),
    .resync_needed   (out_if.resync_needed),
    .limit_byte      (out_if.limit_byte),
    .speed_a         (out_if.speed_a),
    .speed_b         (out_if.speed_b),
    .direction_flags (out_if.direction_flags),
    .sensor_byte     (out_if.sensor_byte)
  );

endmodule
